// ===== rtl/ppd_pkg.sv =====
// ----------------------------------------------------------------------------
// ppd_pkg
// Shared widths and result codes for the point to polygon distance block.
// ----------------------------------------------------------------------------
`default_nettype none
package ppd_pkg;
  localparam int CoordW = 24;
  localparam int FracT  = 32;
  localparam logic [1:0] POS_OUTSIDE  = 2'd0;
  localparam logic [1:0] POS_INSIDE   = 2'd1;
  localparam logic [1:0] POS_BOUNDARY = 2'd2;
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;
  // Squared-length cap in LSB^2.
  localparam logic signed [51:0] CapSq = 52'sd68719476736;
endpackage
`default_nettype wire

// ===== rtl/point_polygon_distance.sv =====
// ----------------------------------------------------------------------------
// point_polygon_distance
// Nearest-boundary vector and inside/outside test for a stored polygon.
// ----------------------------------------------------------------------------
// Usage: the input stream carries loads (tuser = 0) and queries (tuser = 1).
// A load writes one vertex into the store in its transfer cycle and gives no
// result. A query walks every edge of the polygon formed by the first
// vertex_count vertices and gives one result transfer on the output stream:
// the vector to the nearest boundary point and the position code.
// Every product goes through one shared 33x33 multiplier under the sequencer.
// An edge that needs the projection reads both vertices and forms the dot
// and cross products, runs the bit-serial division that finds the projection
// parameter, scales the edge, then squares the vector and updates the best
// edge and the crossing parity. Other edges skip the division and the
// scaling; an edge that holds the point ends the walk. While a query is in
// work, in_tready is low. A finished result waits in the output register.
// While the receiver stalls the next item is still taken; a second result
// holds the sequencer until the first has been taken. Reset (rst_n low,
// synchronous) clears vertex_count and the control state; the vertex store
// is undefined until written. cfg_wr_en/cfg_wr_data write vertex_count;
// the user must write it only while no query is in work: the block itself
// does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none
module point_polygon_distance #(
  parameter int MAX_VERTICES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [6:0]  cfg_wr_data,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // tdata: vertex_index[5:0], coord_x[29:6], coord_y[53:30], zero pad [55:54]
  input  wire logic [55:0] in_tdata,
  // tuser: req_type
  input  wire logic        in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // tdata: near_dx[23:0], near_dy[47:24], position[49:48], zero pad [55:50]
  output logic [55:0]      out_tdata
);
  import ppd_pkg::*;

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = AW + 1;

  typedef enum logic [4:0] {
    S_IDLE, S_RD_A, S_RD_B, S_LATCH, S_M0, S_M1, S_M2, S_M3, S_M4, S_M5,
    S_DECIDE, S_DIV, S_SC0, S_SC1, S_SC2, S_SQ0, S_SQ1, S_EVAL, S_DONE
  } state_t;

  state_t state_r;
  logic [47:0] mem [MAX_VERTICES];
  logic [47:0] rd_q;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] n_r, k_r;
  logic [6:0] vcount_r;
  logic signed [23:0] px_r, py_r, ax_r, ay_r, ex_r, ey_r;
  logic signed [25:0] dx_r, dy_r, wx_r, wy_r;
  logic signed [51:0] p_r, den_r, tn_r, cr_r, s_r, sq_r, best_r;
  logic signed [25:0] bx_r, by_r, vx_r, vy_r;
  logic [51:0] rem_r;
  logic [32:0] q_r;
  logic [57:0] sp_r;
  logic [5:0] dcnt_r;
  logic [1:0] pos_r;
  logic left_r, right_r;
  logic [55:0] out_r;
  logic ov_r;

  // Shared multiplier: 33x33 signed, used by every product of the walk.
  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;
  logic signed [51:0] mp52;
  assign mp   = ma * mb;
  assign mp52 = mp[51:0];

  logic [25:0] absdx, absdy;
  assign absdx = dx_r[25] ? -dx_r : dx_r;
  assign absdy = dy_r[25] ? -dy_r : dy_r;

  always_comb begin
    ma = '0; mb = '0;
    unique case (state_r)
      S_M0: begin ma = 33'(dx_r); mb = 33'(dx_r); end
      S_M1: begin ma = 33'(dy_r); mb = 33'(dy_r); end
      S_M2: begin ma = 33'(wx_r); mb = 33'(dx_r); end
      S_M3: begin ma = 33'(wy_r); mb = 33'(dy_r); end
      S_M4: begin ma = 33'(dx_r); mb = 33'(wy_r); end
      S_M5: begin ma = 33'(dy_r); mb = 33'(wx_r); end
      S_SC0: begin ma = {7'd0, absdx}; mb = {1'b0, q_r[31:0]}; end
      S_SC1: begin ma = {7'd0, absdy}; mb = {1'b0, q_r[31:0]}; end
      S_SQ0: begin ma = 33'(vx_r); mb = 33'(vx_r); end
      S_SQ1: begin ma = 33'(vy_r); mb = 33'(vy_r); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  // Offset along the edge: |d| * t rounded, with the sign of d put back.
  // A quotient of exactly one puts the foot on the far vertex.
  logic signed [25:0] sc_d;
  logic [25:0] sround;
  logic signed [25:0] soff;
  assign sc_d   = (state_r == S_SC1) ? dx_r : dy_r;
  assign sround = 26'((sp_r + 58'h80000000) >> FracT);
  assign soff   = q_r[32] ? sc_d : (sc_d[25] ? -$signed(sround) : $signed(sround));

  logic [52:0] rem_sh;
  assign rem_sh = {rem_r, 1'b0};

  function automatic logic [23:0] sat(input logic signed [25:0] v);
    if (v > 26'sd8388607) return 24'h7FFFFF;
    else if (v < -26'sd8388608) return 24'h800000;
    else return v[23:0];
  endfunction

  assign rd_addr = (state_r == S_RD_A) ? k_r[AW-1:0]
                 : ((k_r + CW'(1) == n_r) ? '0 : AW'(k_r + CW'(1)));
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready && in_tuser == REQ_LOAD
        && 32'(in_tdata[5:0]) < MAX_VERTICES)
      mem[AW'(in_tdata[5:0])] <= in_tdata[53:6];
    rd_q <= mem[rd_addr];
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; vcount_r <= '0; ov_r <= 1'b0;
    end else begin
      if (cfg_wr_en) vcount_r <= cfg_wr_data;
      if (ov_r && out_tready) ov_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_tvalid && in_tready && in_tuser == REQ_QUERY) begin
          px_r <= in_tdata[29:6]; py_r <= in_tdata[53:30];
          n_r <= (32'(vcount_r) > MAX_VERTICES) ? CW'(MAX_VERTICES) : CW'(vcount_r);
          k_r <= '0; best_r <= CapSq; bx_r <= '0; by_r <= '0;
          pos_r <= POS_OUTSIDE; left_r <= 1'b0; right_r <= 1'b0;
          if (32'(vcount_r) < 2) state_r <= S_DONE;
          else state_r <= S_RD_A;
        end
        S_RD_A: state_r <= S_RD_B;
        S_RD_B: begin
          ax_r <= rd_q[23:0]; ay_r <= rd_q[47:24];
          state_r <= S_LATCH;
        end
        S_LATCH: begin
          ex_r <= rd_q[23:0]; ey_r <= rd_q[47:24];
          dx_r <= 26'($signed(rd_q[23:0])) - 26'(ax_r);
          dy_r <= 26'($signed(rd_q[47:24])) - 26'(ay_r);
          wx_r <= 26'(px_r) - 26'(ax_r);
          wy_r <= 26'(py_r) - 26'(ay_r);
          state_r <= S_M0;
        end
        S_M0: begin p_r <= mp52; state_r <= S_M1; end
        S_M1: begin den_r <= p_r + mp52; state_r <= S_M2; end
        S_M2: begin p_r <= mp52; state_r <= S_M3; end
        S_M3: begin tn_r <= p_r + mp52; state_r <= S_M4; end
        S_M4: begin p_r <= mp52; state_r <= S_M5; end
        S_M5: begin
          cr_r <= p_r - mp52;
          // Crossing sign term: (ax-px)(ay-ey) + (ax-ex)(py-ay) = wx*dy - dx*wy.
          s_r <= mp52 - p_r;
          state_r <= S_DECIDE;
        end
        S_DECIDE: begin
          if (den_r == 0) begin
            if (wx_r == 0 && wy_r == 0) begin
              pos_r <= POS_BOUNDARY; state_r <= S_DONE;
            end else begin
              vx_r <= -wx_r; vy_r <= -wy_r; state_r <= S_SQ0;
            end
          end else if (cr_r == 0 && !tn_r[51] && tn_r <= den_r) begin
            pos_r <= POS_BOUNDARY; state_r <= S_DONE;
          end else if (tn_r[51]) begin
            vx_r <= -wx_r; vy_r <= -wy_r; state_r <= S_SQ0;
          end else if (tn_r > den_r) begin
            vx_r <= 26'(ex_r) - 26'(px_r); vy_r <= 26'(ey_r) - 26'(py_r);
            state_r <= S_SQ0;
          end else begin
            rem_r <= tn_r; q_r <= '0; dcnt_r <= '0; state_r <= S_DIV;
          end
        end
        S_DIV: begin
          // One quotient bit per cycle: first the integer bit, then 32.
          if (dcnt_r == 0) begin
            if (rem_r >= den_r) begin
              rem_r <= rem_r - den_r; q_r <= 33'd1;
            end
          end else begin
            if (rem_sh >= {1'b0, den_r}) begin
              rem_r <= 52'(rem_sh - {1'b0, den_r}); q_r <= {q_r[31:0], 1'b1};
            end else begin
              rem_r <= rem_sh[51:0]; q_r <= {q_r[31:0], 1'b0};
            end
          end
          dcnt_r <= dcnt_r + 6'd1;
          if (dcnt_r == 6'd32) state_r <= S_SC0;
        end
        S_SC0: begin
          sp_r <= mp[57:0]; state_r <= S_SC1;
        end
        S_SC1: begin
          vx_r <= 26'(ax_r) + soff - 26'(px_r);
          sp_r <= mp[57:0]; state_r <= S_SC2;
        end
        S_SC2: begin
          vy_r <= 26'(ay_r) + soff - 26'(py_r);
          state_r <= S_SQ0;
        end
        S_SQ0: begin p_r <= mp52; state_r <= S_SQ1; end
        S_SQ1: begin sq_r <= p_r + mp52; state_r <= S_EVAL; end
        S_EVAL: begin
          if (sq_r < best_r) begin
            best_r <= sq_r; bx_r <= vx_r; by_r <= vy_r;
          end
          if (dy_r != 0 && ((ay_r <= py_r) != (ey_r <= py_r)) && s_r != 0) begin
            // Here !dy_r[25] means ay < ey, i.e. dy > 0.
            if ((!s_r[51]) != (!dy_r[25])) right_r <= !right_r;
            else left_r <= !left_r;
          end
          if (k_r + CW'(1) == n_r) state_r <= S_DONE;
          else begin
            k_r <= k_r + CW'(1); state_r <= S_RD_A;
          end
        end
        S_DONE: if (!ov_r) begin
          if (pos_r == POS_OUTSIDE && left_r && right_r && n_r >= CW'(2)) begin
            out_r <= {6'd0, POS_INSIDE, 48'd0};
          end else if (pos_r != POS_OUTSIDE || n_r < CW'(2)) begin
            out_r <= {6'd0, pos_r, 48'd0};
          end else begin
            out_r <= {6'd0, pos_r, sat(by_r), sat(bx_r)};
          end
          ov_r <= 1'b1; state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
